// ===== hdl/psc_pkg.sv =====
// Package for the packet sequence checker: register indexes, field
// positions, reset values and the source count clamp.
// No dependencies.
package psc_pkg;

  // Configuration register indexes
  localparam logic CfgSourceCount = 1'b0;
  localparam logic CfgRunLimit    = 1'b1;

  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 16;

  // Input word actions
  localparam logic ActCheck  = 1'b0;
  localparam logic ActResync = 1'b1;

  // Status word fields
  localparam int PktLsb = 16;
  localparam int PktW   = 16;
  localparam int SrcLsb = 2;
  localparam int SrcW   = 4;

  localparam int CntW     = 32;
  localparam int CountW   = 5;
  localparam int RunW     = 16;

  localparam logic [CountW-1:0] SourceCountReset = 5'd16;
  localparam logic [RunW-1:0]   RunLimitReset    = 16'd100;
  localparam logic [PktW-1:0]   PktMax           = 16'hFFFF;

  // Zero and anything above sixteen behave as sixteen sources
  function automatic logic [CountW-1:0] eff_count(input logic [CountW-1:0] cnt);
    logic [CountW-1:0] res;
    res = cnt;
    if (cnt == '0 || cnt > 5'd16) begin
      res = 5'd16;
    end
    return res;
  endfunction

endpackage

// ===== hdl/packet_sequence_checker.sv =====
// Packet sequence checker: checks source round robin order and packet
// number continuity of status words, keeps saturating error totals.
// Depends on psc_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one word: action_i
//   (0 check, 1 resync) and status_word_i. Every input word yields exactly
//   one result word on the output channel (out_valid_o / out_ready_i).
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at
//   once; index 0 is source_count, index 1 is run_limit. Write only while
//   the block is idle.
//   A check word runs the division steps, the source compare and the adder
//   steps below, then the final step; a resync word goes straight to the
//   final step. One 33-bit adder is shared by the adding steps: five
//   restoring-division steps for the next expected source, then one step
//   each for the source total, the packet number increment, the sequence
//   total, the run length and the terminate compare. Words are accepted only while idle.
//   The result sits in an output register, so the next word is accepted
//   while a result waits; a word whose result cannot be posted waits in
//   the final step until the receiver takes the old one.
//   Reset clears the expectations, totals, run, terminate flag and loads
//   source_count 16 and run_limit 100; no result is pending after reset.
module packet_sequence_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [psc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [psc_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        action_i,
  input  logic [31:0]                 status_word_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        source_error_o,
  output logic                        sequence_error_o,
  output logic [31:0]                 source_error_total_o,
  output logic [31:0]                 sequence_error_total_o,
  output logic [15:0]                 error_run_o,
  output logic                        terminate_o
);
  import psc_pkg::*;

  // Sequencer states
  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StMod  = 4'd1;
  localparam logic [3:0] StSrc  = 4'd2;
  localparam logic [3:0] StSCnt = 4'd3;
  localparam logic [3:0] StPkt  = 4'd4;
  localparam logic [3:0] StQCnt = 4'd5;
  localparam logic [3:0] StRun  = 4'd6;
  localparam logic [3:0] StTerm = 4'd7;
  localparam logic [3:0] StDone = 4'd8;

  localparam logic [2:0] ModTop = 3'd4;

  logic [3:0]        state_q, state_d;
  logic [2:0]        step_q, step_d;
  logic [CountW-1:0] src_count_q;
  logic [RunW-1:0]   run_limit_q;

  logic              act_q;
  logic [PktW-1:0]   pkt_q;
  logic [SrcW-1:0]   src_q;
  logic [CountW-1:0] rem_q, rem_d;

  logic [SrcW-1:0]   exp_src_q, exp_src_d;
  logic              src_known_q, src_known_d;
  logic [PktW-1:0]   last_pkt_q, last_pkt_d;
  logic              pkt_known_q, pkt_known_d;
  logic              in_run_q, in_run_d;
  logic [RunW-1:0]   run_q, run_d;
  logic [CntW-1:0]   src_cnt_q, src_cnt_d;
  logic [CntW-1:0]   seq_cnt_q, seq_cnt_d;
  logic              term_q, term_d;
  logic              src_err_q, src_err_d;
  logic              seq_err_q, seq_err_d;

  logic              out_valid_q, out_valid_d;
  logic              out_src_err_q, out_seq_err_q;
  logic [CntW-1:0]   out_src_cnt_q, out_seq_cnt_q;
  logic [RunW-1:0]   out_run_q;
  logic              out_term_q;

  logic              in_acc;
  logic              post;
  logic [CountW-1:0] count_eff;
  logic [8:0]        div_sh;

  // Shared adder: sum = a + b + cin
  logic [CntW-1:0]   alu_a, alu_b;
  logic              alu_cin;
  logic [CntW:0]     alu_sum;
  logic              alu_co;

  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign count_eff  = eff_count(src_count_q);
  assign div_sh     = {4'b0, count_eff} << step_q;
  assign post       = (state_q == StDone) && (!out_valid_q || out_ready_i);

  // Operand select for the shared adder
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_cin = 1'b1;
    case (state_q)
      StMod: begin
        alu_a = {27'b0, rem_q};
        alu_b = ~{23'b0, div_sh};
      end
      StSCnt: alu_a = src_cnt_q;
      StPkt:  alu_a = {16'b0, last_pkt_q};
      StQCnt: alu_a = seq_cnt_q;
      StRun:  alu_a = {16'b0, run_q};
      StTerm: begin
        alu_a = {16'b0, run_limit_q};
        alu_b = ~{16'b0, run_q};
      end
      default: alu_cin = 1'b0;
    endcase
  end

  assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b} + {{CntW{1'b0}}, alu_cin};
  assign alu_co  = alu_sum[CntW];

  // Sequencer
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    rem_d       = rem_q;
    exp_src_d   = exp_src_q;
    src_known_d = src_known_q;
    last_pkt_d  = last_pkt_q;
    pkt_known_d = pkt_known_q;
    in_run_d    = in_run_q;
    run_d       = run_q;
    src_cnt_d   = src_cnt_q;
    seq_cnt_d   = seq_cnt_q;
    term_d      = term_q;
    src_err_d   = src_err_q;
    seq_err_d   = seq_err_q;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          src_err_d = 1'b0;
          seq_err_d = 1'b0;
          step_d    = ModTop;
          rem_d     = {1'b0, status_word_i[SrcLsb +: SrcW]} + 5'd1;
          if (action_i == ActResync) begin
            // resync: forget both expectations, keep totals
            src_known_d = 1'b0;
            pkt_known_d = 1'b0;
            exp_src_d   = '0;
            last_pkt_d  = '0;
            state_d     = StDone;
          end else begin
            state_d = StMod;
          end
        end
      end
      StMod: begin
        // restoring division step: subtract count << step when it fits
        if (alu_co) begin
          rem_d = alu_sum[CountW-1:0];
        end
        step_d = step_q - 3'd1;
        if (step_q == '0) begin
          state_d = StSrc;
        end
      end
      StSrc: begin
        src_err_d   = src_known_q && (exp_src_q != src_q);
        exp_src_d   = rem_q[SrcW-1:0];
        src_known_d = 1'b1;
        state_d     = StSCnt;
      end
      StSCnt: begin
        if (src_err_q && !alu_co) begin
          src_cnt_d = alu_sum[CntW-1:0];
        end
        state_d = StPkt;
      end
      StPkt: begin
        seq_err_d = pkt_known_q && (last_pkt_q != PktMax) &&
                    (alu_sum[PktW-1:0] != pkt_q);
        state_d   = StQCnt;
      end
      StQCnt: begin
        if (seq_err_q && !alu_co) begin
          seq_cnt_d = alu_sum[CntW-1:0];
        end
        state_d = StRun;
      end
      StRun: begin
        if (pkt_known_q) begin
          if (seq_err_q) begin
            in_run_d = 1'b1;
            if (!alu_sum[RunW]) begin
              run_d = alu_sum[RunW-1:0];
            end
          end else begin
            in_run_d = 1'b0;
            run_d    = '0;
          end
        end
        last_pkt_d  = pkt_q;
        pkt_known_d = 1'b1;
        state_d     = StTerm;
      end
      StTerm: begin
        // borrow out of limit - run means run exceeds the limit
        if (!alu_co) begin
          term_d = 1'b1;
        end
        state_d = StDone;
      end
      StDone: begin
        if (post) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Output register handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (post) begin
      out_valid_d = 1'b1;
    end
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      src_count_q <= SourceCountReset;
      run_limit_q <= RunLimitReset;
      exp_src_q   <= '0;
      src_known_q <= 1'b0;
      last_pkt_q  <= '0;
      pkt_known_q <= 1'b0;
      in_run_q    <= 1'b0;
      run_q       <= '0;
      src_cnt_q   <= '0;
      seq_cnt_q   <= '0;
      term_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      exp_src_q   <= exp_src_d;
      src_known_q <= src_known_d;
      last_pkt_q  <= last_pkt_d;
      pkt_known_q <= pkt_known_d;
      in_run_q    <= in_run_d;
      run_q       <= run_d;
      src_cnt_q   <= src_cnt_d;
      seq_cnt_q   <= seq_cnt_d;
      term_q      <= term_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgSourceCount: src_count_q <= cfg_data_i[CountW-1:0];
          CfgRunLimit:    run_limit_q <= cfg_data_i[RunW-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    src_err_q <= src_err_d;
    seq_err_q <= seq_err_d;
    if (in_acc) begin
      act_q <= action_i;
      pkt_q <= status_word_i[PktLsb +: PktW];
      src_q <= status_word_i[SrcLsb +: SrcW];
    end
    if (post) begin
      out_src_err_q <= src_err_q && (act_q != ActResync);
      out_seq_err_q <= seq_err_q && (act_q != ActResync);
      out_src_cnt_q <= src_cnt_q;
      out_seq_cnt_q <= seq_cnt_q;
      out_run_q     <= run_q;
      out_term_q    <= term_q;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign source_error_o         = out_src_err_q;
  assign sequence_error_o       = out_seq_err_q;
  assign source_error_total_o   = out_src_cnt_q;
  assign sequence_error_total_o = out_seq_cnt_q;
  assign error_run_o            = out_run_q;
  assign terminate_o            = out_term_q;

`ifndef SYNTHESIS
  // terminate never clears once set
  a_term_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    term_q |=> term_q)
    else $error("terminate flag cleared");

  // remainder is below the source count once division ends
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSrc) |-> (rem_q < count_eff))
    else $error("source remainder out of range");

  // a reported sequence error always shows a nonzero run
  a_run_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_seq_err_q) |-> (out_run_q != '0))
    else $error("sequence error with empty run");

  // totals never step back
  a_cnt_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 (src_cnt_q >= $past(src_cnt_q)) && (seq_cnt_q >= $past(seq_cnt_q)))
    else $error("error total decreased");
`endif

endmodule
